// ----- src/first_fit_pool_allocator_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit pool allocator
// Clocked concurrent checks that compile away when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_POOL_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define FFPA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FFPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FFPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/ffpa_pkg.sv -----
// ---------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit pool allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffpa_pkg;

	localparam int unsigned AW = 16; // extent start / block address
	localparam int unsigned LW = 17; // extent length / free total
	localparam int unsigned SW = 18; // rounded request size
	localparam int unsigned EW = 19; // address + size sums
	localparam int unsigned DW = AW + LW; // table entry {start, length}

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FAIL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_RND1,
		S_RND2,
		S_DISP,
		S_RD,
		S_CHK,
		S_FREE,
		S_DNRD,
		S_DNWR,
		S_UPRD,
		S_UPWR,
		S_DONE
	} state_t;

endpackage

// ----- src/first_fit_pool_allocator_unit.sv -----
// First-fit pool allocator. A request runs through two rounding steps, dispatch, a read
// and a check per extent entry scanned and a read and a write per entry shifted, plus a
// step each for a scan that runs off the table end, the free neighbor check and the last
// shift step, then done. One request at a time: the next is accepted in the cycle after
// its response is registered, later while a response waits.
// Reset (arst_n low) clears control; the S_INIT state after it writes the pool-wide extent.
// ---------------------------------------------------------------------------
// first_fit_pool_allocator_unit
// Address-ordered free extent table with first-fit allocate and coalescing free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_pool_allocator_unit_macros.svh"

module first_fit_pool_allocator_unit
	import ffpa_pkg::*;
#(
	parameter int unsigned POOL_BYTES    = 65536,
	parameter int unsigned GRANULE_BYTES = 16,
	parameter int unsigned MAX_EXTENTS   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // req_size[16:0], block_addr[32:17], zero pad
	input  logic        s_axis_tuser,  // func (0 allocate, 1 free)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // result_addr[15:0], status[17:16], free_total[34:18]
);

	localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
	localparam int unsigned IW = $clog2(MAX_EXTENTS);
	localparam int unsigned GW = $clog2(GRANULE_BYTES + 1);
	localparam int unsigned SH = SW + $clog2(GRANULE_BYTES);
	localparam int unsigned RW = SH + 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << SH) + GRANULE_BYTES - 1) / GRANULE_BYTES;
	localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
	localparam logic [EW-1:0] POOL_E = EW'(POOL_BYTES);

	state_t state_q, state_d;

	logic          func_q;
	logic [LW-1:0] req_q;
	logic [AW-1:0] baddr_q;
	logic [SW-1:0] size_q;
	logic [SW+RW-1:0] prod_q;
	logic [CW-1:0] idx_q, ins_q, cnt_q;
	logic [LW-1:0] free_q;
	logic [AW-1:0] pst_q, nst_q;
	logic [LW-1:0] plen_q, nlen_q;
	logic          hn_q;
	logic [AW-1:0] res_q;
	status_t       stat_q;
	logic          ov_q;
	logic [39:0]   odata_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [DW-1:0] ram_wdata, ram_rdata;

	logic [AW-1:0] r_st;
	logic [LW-1:0] r_len;
	logic [CW-1:0] idx_p1, idx_m1;
	logic [EW-1:0] end_e, pend_e, len_e, size_e, addr_e;
	logic          has_prev, ovl, jp, jn, fit, exact, out_free;
	logic [SW-1:0] quot;

	ffpa_ram #(.WIDTH(DW), .DEPTH(MAX_EXTENTS)) u_tbl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign r_st     = ram_rdata[DW-1:LW];
	assign r_len    = ram_rdata[LW-1:0];
	assign idx_p1   = idx_q + CW'(1);
	assign idx_m1   = idx_q - CW'(1);
	assign size_e   = EW'(size_q);
	assign addr_e   = EW'(baddr_q);
	assign end_e    = addr_e + size_e;
	assign pend_e   = EW'(pst_q) + EW'(plen_q);
	assign len_e    = EW'(r_len);
	assign fit      = len_e >= size_e;
	assign exact    = len_e == size_e;
	assign has_prev = idx_q != '0;
	// overlap with the neighbor below or above makes the free invalid
	assign ovl      = (has_prev && pend_e > addr_e) || (hn_q && end_e > EW'(nst_q));
	assign jp       = has_prev && pend_e == addr_e;
	assign jn       = hn_q && end_e == EW'(nst_q);
	assign quot     = prod_q[SH +: SW];
	assign out_free = !ov_q || m_axis_tready;

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = odata_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (s_axis_tvalid) state_d = S_RND1;
			end
			S_RND1: state_d = S_RND2;
			S_RND2: state_d = S_DISP;
			S_DISP: begin
				if (size_q == '0 || (func_q && end_e > POOL_E)) state_d = S_DONE;
				else state_d = S_RD;
			end
			S_RD: begin
				if (idx_q == cnt_q) state_d = func_q ? S_FREE : S_DONE;
				else state_d = S_CHK;
			end
			S_CHK: begin
				if (func_q) begin
					state_d = (EW'(r_st) > addr_e) ? S_FREE : S_RD;
				end else if (fit) begin
					state_d = exact ? S_DNRD : S_DONE;
				end else begin
					state_d = S_RD;
				end
			end
			S_FREE: begin
				if (ovl) state_d = S_DONE;
				else if (jp && jn) state_d = S_DNRD;
				else if (jp || jn) state_d = S_DONE;
				else if (cnt_q == CW'(MAX_EXTENTS)) state_d = S_DONE;
				else state_d = S_UPRD;
			end
			S_DNRD: state_d = (idx_p1 >= cnt_q) ? S_DONE : S_DNWR;
			S_DNWR: state_d = S_DNRD;
			S_UPRD: state_d = (idx_q == ins_q) ? S_DONE : S_UPWR;
			S_UPWR: state_d = S_UPRD;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// table port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IW-1:0];
		ram_wdata = {r_st, r_len};
		ram_raddr = idx_q[IW-1:0];
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = {AW'(0), LW'(POOL_BYTES)};
			end
			S_CHK: begin
				if (!func_q && fit && !exact) begin
					ram_we    = 1'b1;
					ram_wdata = {r_st, r_len - LW'(size_q)};
				end
			end
			S_FREE: begin
				if (!ovl && jp) begin
					ram_we    = 1'b1;
					ram_waddr = idx_m1[IW-1:0];
					ram_wdata = {pst_q, jn ? plen_q + LW'(size_q) + nlen_q
						: plen_q + LW'(size_q)};
				end else if (!ovl && jn) begin
					ram_we    = 1'b1;
					ram_wdata = {baddr_q, nlen_q + LW'(size_q)};
				end
			end
			S_DNRD: ram_raddr = idx_p1[IW-1:0];
			S_DNWR: ram_we = 1'b1;
			S_UPRD: begin
				ram_raddr = idx_m1[IW-1:0];
				if (idx_q == ins_q) begin
					ram_we    = 1'b1;
					ram_wdata = {baddr_q, LW'(size_q)};
				end
			end
			S_UPWR: ram_we = 1'b1;
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= CW'(1);
			free_q  <= LW'(POOL_BYTES);
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) ov_q <= 1'b1;
			else if (ov_q && m_axis_tready) ov_q <= 1'b0;
			case (state_q)
				S_DNRD: begin
					if (idx_p1 >= cnt_q) cnt_q <= cnt_q - CW'(1);
				end
				S_UPRD: begin
					if (idx_q == ins_q) begin
						cnt_q  <= cnt_q + CW'(1);
						free_q <= free_q + LW'(size_q);
					end
				end
				S_CHK: begin
					if (!func_q && fit) free_q <= free_q - LW'(size_q);
				end
				S_FREE: begin
					if (!ovl && (jp || jn)) free_q <= free_q + LW'(size_q);
				end
				default: ;
			endcase
		end
	end

	// request payload and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q  <= s_axis_tuser;
				req_q   <= s_axis_tdata[16:0];
				baddr_q <= s_axis_tdata[32:17];
				res_q   <= '0;
				stat_q  <= ST_OK;
				idx_q   <= '0;
				hn_q    <= 1'b0;
			end
			S_RND1: prod_q <= (SW+RW)'(SW'(req_q) + SW'(GRANULE_BYTES - 1))
				* (SW+RW)'(RECIP);
			S_RND2: size_q <= SW'(quot * GW'(GRANULE_BYTES));
			S_DISP: begin
				if (size_q == '0) stat_q <= ST_FAIL;
				else if (func_q && end_e > POOL_E) stat_q <= ST_RANGE;
			end
			S_RD: begin
				if (idx_q == cnt_q && !func_q) stat_q <= ST_FAIL;
			end
			S_CHK: begin
				if (func_q) begin
					if (EW'(r_st) > addr_e) begin
						hn_q   <= 1'b1;
						nst_q  <= r_st;
						nlen_q <= r_len;
					end else begin
						pst_q  <= r_st;
						plen_q <= r_len;
						idx_q  <= idx_p1;
					end
				end else if (fit) begin
					res_q <= exact ? r_st : AW'(EW'(r_st) + len_e - size_e);
				end else begin
					idx_q <= idx_p1;
				end
			end
			S_FREE: begin
				ins_q <= idx_q;
				if (ovl) stat_q <= ST_RANGE;
				else if (!jp && !jn && cnt_q == CW'(MAX_EXTENTS)) stat_q <= ST_FULL;
				else if (!jp && !jn) idx_q <= cnt_q;
			end
			S_DNWR: idx_q <= idx_p1;
			S_UPWR: idx_q <= idx_m1;
			S_DONE: begin
				// hold the waiting response until it is taken
				if (out_free) odata_q <= {5'd0, free_q, stat_q, res_q};
			end
			default: ;
		endcase
	end

	`FFPA_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CW'(MAX_EXTENTS), "extent count overflow")
	`FFPA_ASSERT(a_free_bound, clk, arst_n, EW'(free_q) <= POOL_E, "free total above pool")
	`FFPA_ASSERT_NEXT(a_ins_room, clk, arst_n, state_q == S_UPRD && idx_q == ins_q,
		cnt_q <= CW'(MAX_EXTENTS) && cnt_q != '0, "insert into full table")

endmodule

// ----- src/ffpa_ram.sv -----
// ---------------------------------------------------------------------------
// ffpa_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffpa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
